// ===== rtl/core/maf_pkg.sv =====
`timescale 1ns / 1ps
package maf_pkg;

  // fixed field and register widths
  localparam int WIN_CFG_BITS     = 7;
  localparam logic [WIN_CFG_BITS-1:0] WIN_RESET = 7'd8;

  // running sum is kept wide so repeated shrink and grow never wraps it
  localparam int SUM_BITS         = 64;

  // defaults for the top level parameters
  localparam int MAX_WINDOW_DEF   = 64;
  localparam int SAMPLE_BITS_DEF  = 24;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUB,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } maf_state_t;

endpackage

// ===== rtl/core/moving_average_filter_top.sv =====
`timescale 1ns / 1ps
// boxcar moving average over the last window_length samples
// input channel: sample and first_of_block, moved on in_valid high and in_stall low;
//   first_of_block clears the running sum and fill count before the sample counts
// output channel: average, moved on out_valid high and out_stall low; held while stalled
// config: cfg_we writes cfg_wdata into window_length (0 acts as 1, above MAX_WINDOW
//   acts as MAX_WINDOW); write only while no request is in flight
// after an accept the block steps through ST_SUB, ST_PREP, ST_DIV and ST_DONE before
//   the result reaches out_valid; one request is in flight at a time, so a new request
//   is taken only once the block is back in ST_IDLE
// ST_DIV runs the restoring divider, which retires one quotient bit
//   per cycle over the clamped sum magnitude
// a finished average sits in the output register, so the next request is accepted while
//   the receiver stalls; the block then waits in its last step until the register frees
// reset (rst, synchronous) clears sum, fill count, write pointer and output valid and
//   loads window_length with 8; the sample ring needs no clearing pass
module moving_average_filter_top import maf_pkg::*; #(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          first_of_block,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] average,
  input  logic                          cfg_we,
  input  logic [WIN_CFG_BITS-1:0]       cfg_wdata
);

  // widths derived from the parameters
  localparam int AW     = $clog2(MAX_WINDOW);          // ring address
  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);      // fill count and window
  localparam int WCMP_W = (CNT_W > WIN_CFG_BITS) ? CNT_W : WIN_CFG_BITS;
  localparam int K      = SAMPLE_BITS - 1 + CNT_W;     // divider dividend width
  localparam int DC_W   = $clog2(K);

  localparam logic [CNT_W-1:0] WMAX = CNT_W'(MAX_WINDOW);

  // ring memory
  logic signed [SAMPLE_BITS-1:0] ring [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] ring_rd;

  maf_state_t state, state_next;

  logic [WIN_CFG_BITS-1:0] window_length;
  logic signed [SUM_BITS-1:0] running_sum;
  logic [CNT_W-1:0] fill_count;
  logic [AW-1:0]    write_position;
  logic             sub_pending;

  // divider registers
  logic [K-1:0]     dvd;        // dividend in, quotient out
  logic [CNT_W:0]   rem;
  logic [DC_W-1:0]  div_cnt;
  logic             quot_neg;

  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] average_r;

  // effective window
  logic [WCMP_W-1:0] cfg_ext;
  logic [CNT_W-1:0]  win_eff;

  always_comb begin
    cfg_ext = WCMP_W'(window_length);
    if (cfg_ext == '0) begin
      win_eff = CNT_W'(1);
    end else if (cfg_ext > WCMP_W'(MAX_WINDOW)) begin
      win_eff = WMAX;
    end else begin
      win_eff = CNT_W'(cfg_ext);
    end
  end

  // request acceptance and fill bookkeeping
  logic             in_take;
  logic [CNT_W-1:0] fill_base;
  logic             need_sub;
  logic [CNT_W-1:0] fill_upd;
  logic [AW-1:0]    old_addr;
  logic [AW-1:0]    wpos_upd;
  logic [CNT_W:0]   addr_tmp;
  logic signed [SUM_BITS-1:0] sum_base;

  assign in_stall = (state != ST_IDLE);
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    fill_base = first_of_block ? '0 : fill_count;
    if (fill_base > win_eff) begin
      fill_base = win_eff;
    end
    need_sub = (fill_base >= win_eff);
    fill_upd = need_sub ? win_eff : fill_base + CNT_W'(1);

    // slot that leaves the window, modulo the ring depth
    if ((CNT_W + 1)'(write_position) >= (CNT_W + 1)'(win_eff)) begin
      addr_tmp = (CNT_W + 1)'(write_position) - (CNT_W + 1)'(win_eff);
    end else begin
      addr_tmp = (CNT_W + 1)'(write_position) + (CNT_W + 1)'(MAX_WINDOW)
               - (CNT_W + 1)'(win_eff);
    end
    old_addr = addr_tmp[AW-1:0];

    wpos_upd = (write_position == AW'(MAX_WINDOW - 1)) ? '0 : write_position + AW'(1);
    sum_base = first_of_block ? '0 : running_sum;
  end

  // ring read happens before the write at the same slot, so a full-length window
  // still sees the outgoing sample
  always_ff @(posedge clk) begin
    if (in_take) begin
      ring[write_position] <= sample;
      ring_rd              <= ring[old_addr];
    end
  end

  // magnitude of the sum, clamped so the dividend fits K bits; a clamped value
  // still divides to something that saturates
  logic [SUM_BITS-1:0] sum_mag;
  logic [K-1:0]        dvd_load;

  always_comb begin
    sum_mag = running_sum[SUM_BITS-1] ? (~running_sum + 1'b1) : running_sum;
    if (sum_mag[SUM_BITS-1:K] != '0) begin
      dvd_load = '1;
    end else begin
      dvd_load = sum_mag[K-1:0];
    end
  end

  // one restoring divide step
  logic [CNT_W:0] rem_sh;
  logic           rem_ge;

  always_comb begin
    rem_sh = {rem[CNT_W-1:0], dvd[K-1]};
    rem_ge = (rem_sh >= {1'b0, fill_count});
  end

  // saturate and apply the sign
  logic                          q_big;
  logic signed [SAMPLE_BITS-1:0] q_res;

  always_comb begin
    q_big = (dvd[K-1:SAMPLE_BITS-1] != '0);
    if (quot_neg) begin
      q_res = q_big ? {1'b1, {(SAMPLE_BITS-1){1'b0}}} : -dvd[SAMPLE_BITS-1:0];
    end else begin
      q_res = q_big ? {1'b0, {(SAMPLE_BITS-1){1'b1}}} : dvd[SAMPLE_BITS-1:0];
    end
  end

  logic out_free;
  assign out_free = !out_valid_r || !out_stall;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_take) begin
          state_next = ST_SUB;
        end
      end
      ST_SUB:  state_next = ST_PREP;
      ST_PREP: state_next = ST_DIV;
      ST_DIV: begin
        if (div_cnt == DC_W'(K - 1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length  <= WIN_RESET;
      running_sum    <= '0;
      fill_count     <= '0;
      write_position <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        window_length <= cfg_wdata;
      end
      if (in_take) begin
        running_sum    <= sum_base + SUM_BITS'(sample);
        fill_count     <= fill_upd;
        write_position <= wpos_upd;
      end else if (state == ST_SUB && sub_pending) begin
        running_sum <= running_sum - SUM_BITS'(ring_rd);
      end
      if (state == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      sub_pending <= need_sub;
    end
    unique case (state)
      ST_PREP: begin
        dvd      <= dvd_load;
        rem      <= '0;
        div_cnt  <= '0;
        quot_neg <= running_sum[SUM_BITS-1];
      end
      ST_DIV: begin
        dvd     <= {dvd[K-2:0], rem_ge};
        rem     <= rem_ge ? rem_sh - {1'b0, fill_count} : rem_sh;
        div_cnt <= div_cnt + DC_W'(1);
      end
      ST_DONE: begin
        if (out_free) begin
          average_r <= q_res;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign average   = average_r;

endmodule

// ===== rtl/core/maf_checker.sv =====
`timescale 1ns / 1ps
module maf_checker import maf_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [SAMPLE_BITS-1:0] average
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(average))
    else $error("average changed while stalled");

  // reset leaves the block empty and ready
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("not idle after reset");

  // one request at a time: busy right after an accept and again once the divide has begun
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall ##2 in_stall)
    else $error("request taken while busy");

  // a fresh result never shows up in the cycles right after an accept taken with out_valid low
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !out_valid |=> !out_valid ##1 !out_valid)
    else $error("result too early");

endmodule

bind moving_average_filter_top maf_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_maf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .average   (average)
);
